FILE: sv/pllm_pkg.sv
package pllm_pkg;

   // Defaults for the top level parameters.
   localparam int NODE_COUNT_DEF = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths.
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ERASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_PUSH_START,
      S_PUSH_LINK,
      S_ERASE_WALK,
      S_ERASE_UNLINK,
      S_ERASE_FREE,
      S_CLEAR_START,
      S_CLEAR_WALK,
      S_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_INIT_WR,
      CMD_ACCEPT,
      CMD_NOMEM,
      CMD_PUSH_READ,
      CMD_PUSH_LINK,
      CMD_ERASE_STEP,
      CMD_ERASE_HIT,
      CMD_ERASE_MISS,
      CMD_ERASE_UNLINK,
      CMD_ERASE_FREE,
      CMD_CLEAR_READ,
      CMD_CLEAR_STEP,
      CMD_CLEAR_SPLICE,
      CMD_RESPOND
   } dp_cmd_type;

   typedef struct packed {
      logic init_last;
      logic pool_empty;
      logic list_empty;
      logic walk_hit;
      logic walk_more;
      logic clear_more;
      logic out_free;
   } dp_status_type;

endpackage

FILE: sv/pllm_ram.sv
module pllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/pllm_ctrl.sv
module pllm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [pllm_pkg::MODE_W-1:0]   req_mode,
   input  pllm_pkg::dp_status_type       status,
   output pllm_pkg::dp_cmd_type          cmd,
   output logic                          req_tready
);

   import pllm_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (status.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_mode)
                  MODE_PUSH:  state_in = S_PUSH_START;
                  MODE_ERASE: state_in = S_ERASE_WALK;
                  MODE_CLEAR: state_in = S_CLEAR_START;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_PUSH_START: begin
            state_in = status.pool_empty ? S_DONE : S_PUSH_LINK;
         end
         S_PUSH_LINK: state_in = S_DONE;
         S_ERASE_WALK: begin
            if (status.walk_hit) begin
               state_in = S_ERASE_UNLINK;
            end else if (!status.walk_more) begin
               state_in = S_DONE;
            end
         end
         S_ERASE_UNLINK: state_in = S_ERASE_FREE;
         S_ERASE_FREE:   state_in = S_DONE;
         S_CLEAR_START: begin
            state_in = status.list_empty ? S_DONE : S_CLEAR_WALK;
         end
         S_CLEAR_WALK: begin
            if (!status.clear_more) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      cmd        = CMD_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: cmd = CMD_INIT_WR;
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd = CMD_ACCEPT;
         end
         S_PUSH_START: cmd = status.pool_empty ? CMD_NOMEM : CMD_PUSH_READ;
         S_PUSH_LINK:  cmd = CMD_PUSH_LINK;
         S_ERASE_WALK: begin
            if (status.walk_hit) begin
               cmd = CMD_ERASE_HIT;
            end else if (status.walk_more) begin
               cmd = CMD_ERASE_STEP;
            end else begin
               cmd = CMD_ERASE_MISS;
            end
         end
         S_ERASE_UNLINK: cmd = CMD_ERASE_UNLINK;
         S_ERASE_FREE:   cmd = CMD_ERASE_FREE;
         S_CLEAR_START:  cmd = status.list_empty ? CMD_NONE : CMD_CLEAR_READ;
         S_CLEAR_WALK:   cmd = status.clear_more ? CMD_CLEAR_STEP : CMD_CLEAR_SPLICE;
         S_DONE: begin
            if (status.out_free) cmd = CMD_RESPOND;
         end
         default: cmd = CMD_NONE;
      endcase
   end

endmodule

FILE: sv/pllm_dpath.sv
module pllm_dpath #(
   parameter int NODE_COUNT = 16,
   parameter int DATA_WIDTH = 32,
   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
   localparam int CW = $clog2(NODE_COUNT + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pllm_pkg::dp_cmd_type            cmd,
   output pllm_pkg::dp_status_type         status,
   input  logic [DATA_WIDTH-1:0]           req_value,
   input  logic [NW-1:0]                   req_node_index,
   input  logic                            rsp_tready,
   output logic                            rsp_valid,
   output logic [pllm_pkg::STATUS_W-1:0]   rsp_status,
   output logic [CW-1:0]                   rsp_result_node,
   output logic [CW-1:0]                   rsp_list_size,
   output logic [CW-1:0]                   rsp_free_size
);

   import pllm_pkg::*;

   localparam logic [CW-1:0] NONE = CW'(NODE_COUNT);

   // Control state, initialised by reset.
   logic [CW-1:0] list_head_ff, list_head_in;
   logic [CW-1:0] pool_head_ff, pool_head_in;
   logic [CW-1:0] list_count_ff, list_count_in;
   logic [CW-1:0] pool_count_ff, pool_count_in;
   logic [NW-1:0] init_idx_ff, init_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   logic [CW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         prev_ff, prev_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic                  use_rd_ff, use_rd_in;
   logic [NW-1:0]         target_ff, target_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [CW-1:0]         res_node_ff, res_node_in;

   // Output register.
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [CW-1:0]       out_node_ff, out_node_in;
   logic [CW-1:0]       out_list_ff, out_list_in;
   logic [CW-1:0]       out_free_ff, out_free_in;

   // Link memory and payload memory ports.
   logic          link_wr_en;
   logic [NW-1:0] link_wr_addr;
   logic [CW-1:0] link_wr_data;
   logic [NW-1:0] link_rd_addr;
   logic [CW-1:0] link_rd_data;
   logic          pay_wr_en;

   logic [CW-1:0] cur_now;
   logic [CW-1:0] target_ext;

   pllm_ram #(
      .WIDTH (CW),
      .DEPTH (NODE_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   pllm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NODE_COUNT)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pool_head_ff[NW-1:0]),
      .wr_data (value_ff),
      .rd_addr ('0),
      .rd_data ()
   );

   // During an erase walk the node under test is the link just read, except
   // in the first cycle, where it is the list head captured at accept.
   assign cur_now    = use_rd_ff ? link_rd_data : cur_ff;
   assign target_ext = CW'(target_ff);

   always_comb begin
      status.init_last  = (init_idx_ff == NW'(NODE_COUNT - 1));
      status.pool_empty = !(pool_head_ff < NONE);
      status.list_empty = !(list_head_ff < NONE);
      status.walk_hit   = (cur_now == target_ext) && (target_ext < NONE);
      status.walk_more  = (cur_now < NONE) && (cur_now != target_ext) && (steps_ff < NONE);
      status.clear_more = (link_rd_data < NONE) && (steps_ff < NONE);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      list_head_in  = list_head_ff;
      pool_head_in  = pool_head_ff;
      list_count_in = list_count_ff;
      pool_count_in = pool_count_ff;
      init_idx_in   = init_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      use_rd_in     = use_rd_ff;
      target_in     = target_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      out_status_in = out_status_ff;
      out_node_in   = out_node_ff;
      out_list_in   = out_list_ff;
      out_free_in   = out_free_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = '0;
      link_wr_data  = '0;
      link_rd_addr  = '0;
      pay_wr_en     = 1'b0;

      case (cmd)
         CMD_INIT_WR: begin
            // Node i links to i-1; node 0 ends the chain.
            link_wr_en   = 1'b1;
            link_wr_addr = init_idx_ff;
            link_wr_data = (init_idx_ff == '0) ? NONE : CW'(init_idx_ff) - CW'(1);
            init_idx_in  = init_idx_ff + NW'(1);
         end
         CMD_ACCEPT: begin
            target_in     = req_node_index;
            value_in      = req_value;
            cur_in        = list_head_ff;
            prev_in       = NONE;
            steps_in      = '0;
            use_rd_in     = 1'b0;
            res_status_in = ST_OK;
            res_node_in   = NONE;
         end
         CMD_NOMEM: res_status_in = ST_NOMEM;
         CMD_PUSH_READ: link_rd_addr = pool_head_ff[NW-1:0];
         CMD_PUSH_LINK: begin
            link_wr_en    = 1'b1;
            link_wr_addr  = pool_head_ff[NW-1:0];
            link_wr_data  = list_head_ff;
            pay_wr_en     = 1'b1;
            pool_head_in  = link_rd_data;
            list_head_in  = pool_head_ff;
            list_count_in = list_count_ff + CW'(1);
            if (pool_count_ff != '0) pool_count_in = pool_count_ff - CW'(1);
            res_node_in   = pool_head_ff;
         end
         CMD_ERASE_STEP: begin
            link_rd_addr = cur_now[NW-1:0];
            prev_in      = cur_now;
            steps_in     = steps_ff + CW'(1);
            use_rd_in    = 1'b1;
         end
         CMD_ERASE_HIT: link_rd_addr = target_ff;
         CMD_ERASE_MISS: res_status_in = ST_NOTFOUND;
         CMD_ERASE_UNLINK: begin
            res_node_in = link_rd_data;
            if (prev_ff < NONE) begin
               link_wr_en   = 1'b1;
               link_wr_addr = prev_ff[NW-1:0];
               link_wr_data = link_rd_data;
            end else begin
               list_head_in = link_rd_data;
            end
         end
         CMD_ERASE_FREE: begin
            link_wr_en    = 1'b1;
            link_wr_addr  = target_ff;
            link_wr_data  = pool_head_ff;
            pool_head_in  = target_ext;
            if (list_count_ff != '0) list_count_in = list_count_ff - CW'(1);
            pool_count_in = pool_count_ff + CW'(1);
         end
         CMD_CLEAR_READ: begin
            link_rd_addr = list_head_ff[NW-1:0];
            cur_in       = list_head_ff;
            steps_in     = '0;
         end
         CMD_CLEAR_STEP: begin
            link_rd_addr = link_rd_data[NW-1:0];
            cur_in       = link_rd_data;
            steps_in     = steps_ff + CW'(1);
         end
         CMD_CLEAR_SPLICE: begin
            // cur_ff is the tail: hang the free stack behind it.
            link_wr_en    = 1'b1;
            link_wr_addr  = cur_ff[NW-1:0];
            link_wr_data  = pool_head_ff;
            pool_head_in  = list_head_ff;
            list_head_in  = NONE;
            pool_count_in = pool_count_ff + list_count_ff;
            list_count_in = '0;
         end
         CMD_RESPOND: begin
            rsp_valid_in  = 1'b1;
            out_status_in = res_status_ff;
            out_node_in   = res_node_ff;
            out_list_in   = list_count_ff;
            out_free_in   = pool_count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff  <= NONE;
         pool_head_ff  <= CW'(NODE_COUNT - 1);
         list_count_ff <= '0;
         pool_count_ff <= NONE;
         init_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         list_head_ff  <= list_head_in;
         pool_head_ff  <= pool_head_in;
         list_count_ff <= list_count_in;
         pool_count_ff <= pool_count_in;
         init_idx_ff   <= init_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      use_rd_ff     <= use_rd_in;
      target_ff     <= target_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      out_status_ff <= out_status_in;
      out_node_ff   <= out_node_in;
      out_list_ff   <= out_list_in;
      out_free_ff   <= out_free_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_result_node = out_node_ff;
   assign rsp_list_size   = out_list_ff;
   assign rsp_free_size   = out_free_ff;

endmodule

FILE: sv/pooled_linked_list_manager_unit.sv
// An erase walks the list from its head towards the target node, and a clear
// walks the whole list to its tail; each step is a read of link memory.
// Throughput: one request at a time; the next is accepted the cycle after the
// previous response is loaded into the output register.
// Reset: synchronous, active high; afterwards a pass over every node rebuilds
// the free chain in link memory, and req_tready stays low until it is done.
module pooled_linked_list_manager_unit #(
   parameter int NODE_COUNT = pllm_pkg::NODE_COUNT_DEF,
   parameter int DATA_WIDTH = pllm_pkg::DATA_WIDTH_DEF,
   localparam int NW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
   localparam int CW     = $clog2(NODE_COUNT + 1),
   localparam int REQ_W  = pllm_pkg::MODE_W + DATA_WIDTH + NW,
   localparam int REQ_TW = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W  = pllm_pkg::STATUS_W + 3 * CW,
   localparam int RSP_TW = ((RSP_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   // req_tdata, lowest bits first: mode, value, node_index, zero fill.
   input  logic [REQ_TW-1:0] req_tdata,
   // Response channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // rsp_tdata, lowest bits first: status, result_node, list_size,
   // free_size, zero fill.
   output logic [RSP_TW-1:0] rsp_tdata
);

   import pllm_pkg::*;

   // The block keeps one singly linked list and a free stack in a shared
   // pool of nodes. The link of every node sits in a small memory with a
   // registered read, so walks advance one node per cycle. The controller
   // sequences each request; the datapath holds the heads, the counters,
   // the walk registers and the output register.

   logic [MODE_W-1:0]     req_mode;
   logic [DATA_WIDTH-1:0] req_value;
   logic [NW-1:0]         req_node_index;

   logic [STATUS_W-1:0] rsp_status;
   logic [CW-1:0]       rsp_result_node;
   logic [CW-1:0]       rsp_list_size;
   logic [CW-1:0]       rsp_free_size;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Unpack the request fields.
   assign req_mode       = req_tdata[MODE_W-1:0];
   assign req_value      = req_tdata[MODE_W +: DATA_WIDTH];
   assign req_node_index = req_tdata[MODE_W + DATA_WIDTH +: NW];

   pllm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   pllm_dpath #(
      .NODE_COUNT (NODE_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .req_node_index  (req_node_index),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_result_node (rsp_result_node),
      .rsp_list_size   (rsp_list_size),
      .rsp_free_size   (rsp_free_size)
   );

   // Pack the response fields; the upper bits fill with zeros.
   assign rsp_tdata = RSP_TW'({rsp_free_size, rsp_list_size, rsp_result_node, rsp_status});

endmodule

FILE: sim/pooled_linked_list_manager_unit_tb.sv
module pooled_linked_list_manager_unit_tb;
   import pllm_pkg::*;

   localparam int NODES      = 16;
   localparam int REQ_TW     = 40;
   localparam int RSP_TW     = 24;
   localparam int QUIET_TAIL = 60;    // final requests sent with no idling
   localparam int HOLD_AFTER = 150;   // responses seen before the long hold-off
   localparam int HOLD_LEN   = 300;   // cycles of the long hold-off
   localparam int IDLE_LIMIT = 3000;  // cycles without any handshake before giving up
   localparam int RANDOM_REQS = 550;
   localparam logic [4:0] NO_NODE = 5'd16;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] value;
      logic [3:0]  node_index;
   } list_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] result_node;
      logic [4:0] list_size;
      logic [4:0] free_size;
   } list_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_TW-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_TW-1:0] rsp_tdata;

   // Shadow of the node pool: link of each node, both chain heads and counters.
   logic [4:0] link_mem [NODES];
   logic [4:0] list_top;
   logic [4:0] pool_top;
   logic [4:0] list_len;
   logic [4:0] free_len;

   list_req_type pending_reqs [$];
   list_rsp_type expected_rsps [$];

   int  total_reqs    = 0;
   int  reqs_accepted = 0;
   int  rsps_seen     = 0;
   int  fail_count    = 0;
   int  idle_cycles   = 0;
   bit  req_fire      = 1'b0;
   int  req_gap       = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   bit  hold_done     = 1'b0;

   pooled_linked_list_manager_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // After reset every node sits on the free stack, highest index on top.
   task automatic reset_pool_model();
      for (int i = 0; i < NODES; i++) begin
         link_mem[i] = (i == 0) ? NO_NODE : 5'(i - 1);
      end
      list_top = NO_NODE;
      pool_top = 5'(NODES - 1);
      list_len = '0;
      free_len = 5'(NODES);
   endtask

   // Applies one request to the shadow pool and returns the response it earns.
   function automatic list_rsp_type apply_list_op(input list_req_type rq);
      list_rsp_type r;
      logic [4:0]   prev;
      logic [4:0]   cur;
      logic [4:0]   after;
      int           steps;
      r.status      = ST_OK;
      r.result_node = NO_NODE;
      case (rq.mode)
         MODE_PUSH: begin
            if (pool_top >= NODES) begin
               r.status = ST_NOMEM;
            end else begin
               cur = pool_top;
               pool_top = link_mem[cur[3:0]];
               link_mem[cur[3:0]] = list_top;
               list_top = cur;
               list_len = list_len + 5'd1;
               if (free_len > 0) free_len = free_len - 5'd1;
               r.result_node = cur;
            end
         end
         MODE_ERASE: begin
            prev  = NO_NODE;
            cur   = list_top;
            steps = 0;
            while (cur < NODES && cur != {1'b0, rq.node_index} && steps < NODES) begin
               prev = cur;
               cur  = link_mem[cur[3:0]];
               steps++;
            end
            if (cur != {1'b0, rq.node_index}) begin
               r.status = ST_NOTFOUND;
            end else begin
               after = link_mem[cur[3:0]];
               if (prev < NODES) link_mem[prev[3:0]] = after;
               else list_top = after;
               link_mem[cur[3:0]] = pool_top;
               pool_top = cur;
               if (list_len > 0) list_len = list_len - 5'd1;
               free_len = free_len + 5'd1;
               r.result_node = after;
            end
         end
         MODE_CLEAR: begin
            // The whole list goes onto the free stack in one splice at its tail.
            if (list_top < NODES) begin
               cur   = list_top;
               steps = 0;
               while (link_mem[cur[3:0]] < NODES && steps < NODES) begin
                  cur = link_mem[cur[3:0]];
                  steps++;
               end
               link_mem[cur[3:0]] = pool_top;
               pool_top = list_top;
               list_top = NO_NODE;
               free_len = free_len + list_len;
               list_len = '0;
            end
         end
         default: begin
            // The spare mode code leaves everything untouched.
         end
      endcase
      r.list_size = list_len;
      r.free_size = free_len;
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   function automatic list_req_type make_req(input logic [1:0] mode, input logic [31:0] value,
                                             input logic [3:0] node_index);
      list_req_type rq;
      rq.mode       = mode;
      rq.value      = value;
      rq.node_index = node_index;
      return rq;
   endfunction

   // Request driver: a new request is offered only once the previous one has
   // been taken, with random gaps between requests except in the quiet tail.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // Still waiting for the current request to be taken.
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap--;
      end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(1, 11) - 1;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         list_req_type rq;
         rq = pending_reqs.pop_front();
         req_tdata  <= {2'b0, rq.node_index, rq.value, rq.mode};
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response side: random stalls, plus one long hold-off that lets the block
   // fill up and back-pressure the request channel.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && rsps_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (reqs_accepted < total_reqs - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      if (reset) begin
         reset_pool_model();
         req_fire    = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire = req_tvalid && req_tready;
         idle_cycles++;
         if (req_fire) begin
            list_req_type rq;
            rq = make_req(req_tdata[1:0], req_tdata[33:2], req_tdata[37:34]);
            expected_rsps.push_back(apply_list_op(rq));
            reqs_accepted++;
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               list_rsp_type exp_rsp;
               exp_rsp = expected_rsps.pop_front();
               check_field("status", exp_rsp.status, rsp_tdata[1:0]);
               check_field("result_node", exp_rsp.result_node, rsp_tdata[6:2]);
               check_field("list_size", exp_rsp.list_size, rsp_tdata[11:7]);
               check_field("free_size", exp_rsp.free_size, rsp_tdata[16:12]);
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus, then the end-of-run wait and verdict.
   initial begin
      int kind;
      int burst;
      // Empty list: erase misses, clear does nothing, spare mode is ignored.
      pending_reqs.push_back(make_req(MODE_ERASE, 32'h0, 4'd5));
      pending_reqs.push_back(make_req(MODE_CLEAR, 32'h0, 4'd0));
      pending_reqs.push_back(make_req(2'd3, 32'hFFFF_FFFF, 4'hF));
      // Payload extremes land in nodes 15 down to 12.
      pending_reqs.push_back(make_req(MODE_PUSH, 32'h0000_0000, 4'd0));
      pending_reqs.push_back(make_req(MODE_PUSH, 32'hFFFF_FFFF, 4'hF));
      pending_reqs.push_back(make_req(MODE_PUSH, 32'hAAAA_AAAA, 4'hA));
      pending_reqs.push_back(make_req(MODE_PUSH, 32'h5555_5555, 4'h5));
      // Erase at the head, then the last node, then the same node again.
      pending_reqs.push_back(make_req(MODE_ERASE, 32'h0, 4'd12));
      pending_reqs.push_back(make_req(MODE_ERASE, 32'h0, 4'd15));
      pending_reqs.push_back(make_req(MODE_ERASE, 32'h0, 4'd15));
      // Fill the pool completely, then push once more into an empty pool.
      for (int i = 0; i < 15; i++) begin
         pending_reqs.push_back(make_req(MODE_PUSH, $urandom, 4'($urandom_range(0, 15))));
      end
      // Erase deep in a full list, then clear a near-full list.
      pending_reqs.push_back(make_req(MODE_ERASE, 32'h0, 4'd13));
      pending_reqs.push_back(make_req(MODE_CLEAR, 32'h0, 4'd0));

      // Random part: bursts of pushes and erases keep the list swinging between
      // empty and full, with occasional clears and spare-mode noise.
      while (pending_reqs.size() < RANDOM_REQS) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            burst = $urandom_range(1, 18);
            repeat (burst) begin
               pending_reqs.push_back(make_req(MODE_PUSH, $urandom,
                                               4'($urandom_range(0, 15))));
            end
         end else if (kind < 8) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               pending_reqs.push_back(make_req(MODE_ERASE, $urandom,
                                               4'($urandom_range(0, 15))));
            end
         end else if (kind == 8) begin
            pending_reqs.push_back(make_req(MODE_CLEAR, $urandom, 4'($urandom_range(0, 15))));
         end else begin
            pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), $urandom,
                                            4'($urandom_range(0, 15))));
         end
      end
      total_reqs = pending_reqs.size();

      @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0) begin
         @(negedge clock);
      end
      // Longest walk is well under this; anything extra shows up as an
      // unexpected response.
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/pllm_pkg.sv
sv/pllm_ram.sv
sv/pllm_ctrl.sv
sv/pllm_dpath.sv
sv/pooled_linked_list_manager_unit.sv
sim/pooled_linked_list_manager_unit_tb.sv
